/* design/sd2d_pkg.sv */
package sd2d_pkg;

    localparam int FIELD_W        = 16;
    localparam int OUT_W          = 25;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int LANES          = 4;

    typedef struct packed {
        logic signed [FIELD_W-1:0] first_start_x;
        logic signed [FIELD_W-1:0] first_start_y;
        logic signed [FIELD_W-1:0] first_end_x;
        logic signed [FIELD_W-1:0] first_end_y;
        logic signed [FIELD_W-1:0] second_start_x;
        logic signed [FIELD_W-1:0] second_start_y;
        logic signed [FIELD_W-1:0] second_end_x;
        logic signed [FIELD_W-1:0] second_end_y;
    } t_item;

    typedef struct packed {
        logic             touching;
        logic [OUT_W-1:0] distance_q8;
    } t_result;

    typedef struct packed {
        logic vld;
        logic touch;
    } t_ctl;

endpackage

/* design/sd2d_div.sv */
module sd2d_div #(
    parameter int COORD_BITS = sd2d_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sd2d_pkg::FRAC_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  sd2d_pkg::t_ctl                             i_ctl,
    input  logic [sd2d_pkg::LANES-1:0][4*COORD_BITS+4+2*FRAC_BITS-1:0] i_dvd,
    input  logic [sd2d_pkg::LANES-1:0][2*COORD_BITS+1:0]                i_den,
    output sd2d_pkg::t_ctl                             o_ctl,
    output logic [sd2d_pkg::LANES-1:0][2*COORD_BITS+2+2*FRAC_BITS-1:0] o_quo
);

    localparam int NL  = sd2d_pkg::LANES;
    localparam int LW  = 2 * COORD_BITS + 2;
    localparam int YW  = LW + 2 * FRAC_BITS;
    localparam int DVW = 2 * LW + 2 * FRAC_BITS;

    logic [NL-1:0][LW-1:0] r_rem [YW];
    logic [NL-1:0][LW-1:0] r_den [YW];
    logic [NL-1:0][YW-1:0] r_x   [YW];
    sd2d_pkg::t_ctl        r_ctl [YW];

    for (genvar k = 0; k < YW; k++) begin : g_stg
        logic [NL-1:0][LW-1:0] a_rem;
        logic [NL-1:0][LW-1:0] a_den;
        logic [NL-1:0][YW-1:0] a_x;
        sd2d_pkg::t_ctl        a_ctl;
        logic [NL-1:0][LW-1:0] n_rem;
        logic [NL-1:0][YW-1:0] n_x;
        logic [LW:0]           t  [NL];
        logic [LW:0]           df [NL];
        logic                  ge [NL];

        if (k == 0) begin : g_in
            always_comb begin
                for (int l = 0; l < NL; l++) begin
                    a_rem[l] = i_dvd[l][DVW-1 -: LW];
                    a_x[l]   = i_dvd[l][YW-1:0];
                end
            end
            assign a_den = i_den;
            assign a_ctl = i_ctl;
        end else begin : g_mid
            assign a_rem = r_rem[k-1];
            assign a_x   = r_x[k-1];
            assign a_den = r_den[k-1];
            assign a_ctl = r_ctl[k-1];
        end

        always_comb begin
            for (int l = 0; l < NL; l++) begin
                t[l]     = {a_rem[l], a_x[l][YW-1]};
                ge[l]    = t[l] >= {1'b0, a_den[l]};
                df[l]    = t[l] - {1'b0, a_den[l]};
                n_rem[l] = ge[l] ? df[l][LW-1:0] : t[l][LW-1:0];
                n_x[l]   = {a_x[l][YW-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= a_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_x[k]   <= n_x;
            r_den[k] <= a_den;
        end
    end

    assign o_ctl = r_ctl[YW-1];
    assign o_quo = r_x[YW-1];

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[YW-1].vld |-> (r_rem[YW-1][0] < r_den[YW-1][0]) &&
                            (r_rem[YW-1][1] < r_den[YW-1][1]) &&
                            (r_rem[YW-1][2] < r_den[YW-1][2]) &&
                            (r_rem[YW-1][3] < r_den[YW-1][3]))
        else $error("Divider remainder is not below the divisor.");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[0].vld |-> (r_den[0][0] != '0) && (r_den[0][1] != '0) &&
                         (r_den[0][2] != '0) && (r_den[0][3] != '0))
        else $error("Divider received a zero divisor.");

endmodule

/* design/sd2d_sqrt.sv */
module sd2d_sqrt #(
    parameter int COORD_BITS = sd2d_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sd2d_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sd2d_pkg::t_ctl                         i_ctl,
    input  logic [2*COORD_BITS+2+2*FRAC_BITS-1:0]  i_y,
    output sd2d_pkg::t_ctl                         o_ctl,
    output logic [COORD_BITS+1+FRAC_BITS-1:0]      o_root
);

    localparam int YW = 2 * COORD_BITS + 2 + 2 * FRAC_BITS;
    localparam int QW = YW / 2;

    logic [QW+1:0]  r_rem  [QW];
    logic [QW-1:0]  r_root [QW];
    logic [YW-1:0]  r_y    [QW-1];
    sd2d_pkg::t_ctl r_ctl  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stg
        logic [QW+1:0]  a_rem;
        logic [QW-1:0]  a_root;
        logic [YW-1:0]  a_y;
        sd2d_pkg::t_ctl a_ctl;
        logic [QW+3:0]  t;
        logic [QW+3:0]  trial;
        logic [QW+3:0]  df;
        logic           ge;

        if (k == 0) begin : g_in
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_y    = i_y;
            assign a_ctl  = i_ctl;
        end else begin : g_mid
            assign a_rem  = r_rem[k-1];
            assign a_root = r_root[k-1];
            assign a_y    = r_y[k-1];
            assign a_ctl  = r_ctl[k-1];
        end

        assign t     = {a_rem, a_y[YW-1 -: 2]};
        assign trial = (QW+4)'({a_root, 2'b01});
        assign ge    = t >= trial;
        assign df    = t - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= a_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? df[QW+1:0] : t[QW+1:0];
            r_root[k] <= {a_root[QW-2:0], ge};
        end

        if (k < QW - 1) begin : g_ysh
            always_ff @(posedge i_clk) begin
                r_y[k] <= {a_y[YW-3:0], 2'b00};
            end
        end
    end

    assign o_ctl  = r_ctl[QW-1];
    assign o_root = r_root[QW-1];

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[QW-1].vld |-> r_rem[QW-1] <= (QW+2)'({r_root[QW-1], 1'b0}))
        else $error("Root remainder exceeds twice the root.");

endmodule

/* design/segment_distance_2d_top.sv */
// Throughput is one beat per clock; busy is never raised and results cannot be held off.
// Six arithmetic stages, a pipelined divider with one quotient bit per stage, a two-stage
// minimum and a pipelined root with one result bit per stage make up the pipeline.
// The synchronous active-low reset clears only the valid and touch bits of the pipeline.
module segment_distance_2d_top #(
    parameter int COORD_BITS = sd2d_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sd2d_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sd2d_pkg::t_item   i_item,
    output logic              o_strobe,
    output sd2d_pkg::t_result o_result
);

    localparam int CB    = COORD_BITS;
    localparam int FW    = sd2d_pkg::FIELD_W;
    localparam int OW    = sd2d_pkg::OUT_W;
    localparam int NL    = sd2d_pkg::LANES;
    localparam int DW    = CB + 1;
    localparam int PW    = 2 * DW;
    localparam int LW    = PW;
    localparam int H     = DW;
    localparam int YW    = LW + 2 * FRAC_BITS;
    localparam int QW    = YW / 2;
    localparam int DVW   = 2 * LW + 2 * FRAC_BITS;

    logic [FW-1:0]        w_fld [8];
    logic signed [CB-1:0] w_crd [8];
    logic signed [CB-1:0] w_sx [NL], w_sy [NL], w_ex [NL], w_ey [NL], w_px [NL], w_py [NL];

    assign w_fld[0] = i_item.first_start_x;
    assign w_fld[1] = i_item.first_start_y;
    assign w_fld[2] = i_item.first_end_x;
    assign w_fld[3] = i_item.first_end_y;
    assign w_fld[4] = i_item.second_start_x;
    assign w_fld[5] = i_item.second_start_y;
    assign w_fld[6] = i_item.second_end_x;
    assign w_fld[7] = i_item.second_end_y;

    for (genvar j = 0; j < 8; j++) begin : g_crd
        if (CB <= FW) begin : g_cut
            assign w_crd[j] = signed'(w_fld[j][CB-1:0]);
        end else begin : g_ext
            assign w_crd[j] = signed'({{(CB-FW){1'b0}}, w_fld[j]});
        end
    end

    // Lanes: first segment to second start, first segment to second end,
    // second segment to first start, second segment to first end.
    assign w_sx = '{w_crd[0], w_crd[0], w_crd[4], w_crd[4]};
    assign w_sy = '{w_crd[1], w_crd[1], w_crd[5], w_crd[5]};
    assign w_ex = '{w_crd[2], w_crd[2], w_crd[6], w_crd[6]};
    assign w_ey = '{w_crd[3], w_crd[3], w_crd[7], w_crd[7]};
    assign w_px = '{w_crd[4], w_crd[6], w_crd[0], w_crd[2]};
    assign w_py = '{w_crd[5], w_crd[7], w_crd[1], w_crd[3]};

    assign busy = 1'b0;

    sd2d_pkg::t_ctl r1_ctl, r2_ctl, r3_ctl, r4_ctl, r5_ctl, r6_ctl, r7_ctl, r8_ctl;
    sd2d_pkg::t_ctl r_out_ctl;
    sd2d_pkg::t_ctl n4_ctl, w_div_ctl, w_sq_ctl;

    logic signed [DW-1:0] r1_a [NL], r1_b [NL], r1_c [NL], r1_d [NL], r1_ex [NL], r1_ey [NL];
    logic [NL-1:0]        r1_box, r2_box, r3_box;

    logic signed [PW-1:0] r2_ac [NL], r2_bd [NL], r2_cb [NL], r2_da [NL];
    logic signed [PW-1:0] r2_aa [NL], r2_bb [NL], r2_xx [NL], r2_yy [NL];
    logic signed [PW-1:0] r2_cc [NL], r2_dd [NL];

    logic signed [PW:0]   r3_dot [NL], r3_crs [NL];
    logic [LW-1:0]        r3_len [NL], r3_sd [NL], r3_ed [NL];

    logic [LW-1:0]        r4_num [NL], r4_den [NL];
    logic [NL-1:0]        r4_perp;

    logic [LW-1:0]        r5_hh [NL], r5_hl [NL], r5_ll [NL], r5_num [NL], r5_den [NL];
    logic [NL-1:0]        r5_perp;

    logic [NL-1:0][DVW-1:0] r6_dvd;
    logic [NL-1:0][LW-1:0]  r6_den;

    logic [NL-1:0][YW-1:0]  w_quo;
    logic [YW-1:0]          r7_m0, r7_m1, r8_min;
    logic [QW-1:0]          w_root;
    logic [OW-1:0]          w_sat;
    logic [OW-1:0]          r_out_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl    <= '0;
            r2_ctl    <= '0;
            r3_ctl    <= '0;
            r4_ctl    <= '0;
            r5_ctl    <= '0;
            r6_ctl    <= '0;
            r7_ctl    <= '0;
            r8_ctl    <= '0;
            r_out_ctl <= '0;
        end else begin
            r1_ctl    <= '{vld: start & ~busy, touch: 1'b0};
            r2_ctl    <= r1_ctl;
            r3_ctl    <= r2_ctl;
            r4_ctl    <= n4_ctl;
            r5_ctl    <= r4_ctl;
            r6_ctl    <= r5_ctl;
            r7_ctl    <= w_div_ctl;
            r8_ctl    <= r7_ctl;
            r_out_ctl <= w_sq_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NL; p++) begin
            r1_a[p]   <= DW'(w_px[p]) - DW'(w_sx[p]);
            r1_b[p]   <= DW'(w_py[p]) - DW'(w_sy[p]);
            r1_c[p]   <= DW'(w_ex[p]) - DW'(w_sx[p]);
            r1_d[p]   <= DW'(w_ey[p]) - DW'(w_sy[p]);
            r1_ex[p]  <= DW'(w_px[p]) - DW'(w_ex[p]);
            r1_ey[p]  <= DW'(w_py[p]) - DW'(w_ey[p]);
            r1_box[p] <= ((w_px[p] >= w_sx[p] && w_px[p] <= w_ex[p]) ||
                          (w_px[p] >= w_ex[p] && w_px[p] <= w_sx[p])) &&
                         ((w_py[p] >= w_sy[p] && w_py[p] <= w_ey[p]) ||
                          (w_py[p] >= w_ey[p] && w_py[p] <= w_sy[p]));
        end
    end

    always_ff @(posedge i_clk) begin
        r2_box <= r1_box;
        for (int p = 0; p < NL; p++) begin
            r2_ac[p] <= r1_a[p] * r1_c[p];
            r2_bd[p] <= r1_b[p] * r1_d[p];
            r2_cb[p] <= r1_c[p] * r1_b[p];
            r2_da[p] <= r1_d[p] * r1_a[p];
            r2_aa[p] <= r1_a[p] * r1_a[p];
            r2_bb[p] <= r1_b[p] * r1_b[p];
            r2_xx[p] <= r1_ex[p] * r1_ex[p];
            r2_yy[p] <= r1_ey[p] * r1_ey[p];
            r2_cc[p] <= r1_c[p] * r1_c[p];
            r2_dd[p] <= r1_d[p] * r1_d[p];
        end
    end

    always_ff @(posedge i_clk) begin
        r3_box <= r2_box;
        for (int p = 0; p < NL; p++) begin
            r3_dot[p] <= (PW+1)'(r2_ac[p]) + (PW+1)'(r2_bd[p]);
            r3_crs[p] <= (PW+1)'(r2_cb[p]) - (PW+1)'(r2_da[p]);
            r3_len[p] <= $unsigned(r2_cc[p] + r2_dd[p]);
            r3_sd[p]  <= $unsigned(r2_aa[p] + r2_bb[p]);
            r3_ed[p]  <= $unsigned(r2_xx[p] + r2_yy[p]);
        end
    end

    // The cross product of each lane is also the orientation of its point
    // against its segment.
    logic [NL-1:0] w_neg, w_zro, w_near, w_far;
    logic [PW:0]   w_abs [NL];

    always_comb begin
        for (int p = 0; p < NL; p++) begin
            w_neg[p]  = r3_crs[p][PW];
            w_zro[p]  = (r3_crs[p] == '0);
            w_abs[p]  = w_neg[p] ? $unsigned(-r3_crs[p]) : $unsigned(r3_crs[p]);
            w_near[p] = (r3_len[p] == '0) || r3_dot[p][PW];
            w_far[p]  = r3_dot[p] > $signed({1'b0, r3_len[p]});
        end
        n4_ctl.vld   = r3_ctl.vld;
        n4_ctl.touch = (({w_neg[0], w_zro[0]} != {w_neg[1], w_zro[1]}) &&
                        ({w_neg[2], w_zro[2]} != {w_neg[3], w_zro[3]})) ||
                       (w_zro[0] && r3_box[0]) || (w_zro[1] && r3_box[1]) ||
                       (w_zro[2] && r3_box[2]) || (w_zro[3] && r3_box[3]);
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NL; p++) begin
            r4_perp[p] <= ~w_near[p] & ~w_far[p];
            r4_den[p]  <= r3_len[p];
            if (w_near[p]) begin
                r4_num[p] <= r3_sd[p];
            end else if (w_far[p]) begin
                r4_num[p] <= r3_ed[p];
            end else begin
                r4_num[p] <= w_abs[p][LW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r5_perp <= r4_perp;
        for (int p = 0; p < NL; p++) begin
            r5_hh[p]  <= r4_num[p][LW-1:H] * r4_num[p][LW-1:H];
            r5_hl[p]  <= r4_num[p][LW-1:H] * r4_num[p][H-1:0];
            r5_ll[p]  <= r4_num[p][H-1:0] * r4_num[p][H-1:0];
            r5_num[p] <= r4_num[p];
            r5_den[p] <= r4_den[p];
        end
    end

    logic [DVW-1:0] w_sq [NL];

    always_comb begin
        for (int p = 0; p < NL; p++) begin
            w_sq[p] = (DVW'(r5_hh[p]) << (2 * H)) + (DVW'(r5_hl[p]) << (H + 1)) +
                      DVW'(r5_ll[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NL; p++) begin
            r6_dvd[p] <= (r5_perp[p] ? w_sq[p] : DVW'(r5_num[p])) << (2 * FRAC_BITS);
            r6_den[p] <= r5_perp[p] ? r5_den[p] : LW'(1);
        end
    end

    sd2d_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r6_ctl),
        .i_dvd   (r6_dvd),
        .i_den   (r6_den),
        .o_ctl   (w_div_ctl),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        r7_m0  <= (w_quo[1] < w_quo[0]) ? w_quo[1] : w_quo[0];
        r7_m1  <= (w_quo[3] < w_quo[2]) ? w_quo[3] : w_quo[2];
        r8_min <= (r7_m1 < r7_m0) ? r7_m1 : r7_m0;
    end

    sd2d_sqrt #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r8_ctl),
        .i_y     (r8_min),
        .o_ctl   (w_sq_ctl),
        .o_root  (w_root)
    );

    if (QW > OW) begin : g_sat
        assign w_sat = (|w_root[QW-1:OW]) ? '1 : w_root[OW-1:0];
    end else begin : g_zx
        assign w_sat = OW'(w_root);
    end

    always_ff @(posedge i_clk) begin
        r_out_dist <= w_sq_ctl.touch ? '0 : w_sat;
    end

    assign o_strobe             = r_out_ctl.vld;
    assign o_result.touching    = r_out_ctl.touch;
    assign o_result.distance_q8 = r_out_dist;

    a_touch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.touching |-> o_result.distance_q8 == '0)
        else $error("Touching segments reported a nonzero distance.");

endmodule
